// ----- src/rpc_pkg.sv -----
// ============================================================================
// rpc_pkg
// Shared types and constants of the rectangular/polar CORDIC converter.
// ============================================================================
package rpc_pkg;

    localparam int TAB_LEN = 30;
    localparam int XY_W    = 64;
    localparam int Z_W     = 36;

    localparam logic [1:0] FORM_RECT  = 2'd0;
    localparam logic [1:0] FORM_POLAR = 2'd1;

    localparam logic signed [33:0] PI_Q30         = 34'sd3373259426;
    localparam logic signed [30:0] GAIN_Q30       = 31'sd652032874;
    localparam logic signed [27:0] DEG_TO_RAD_Q32 = 28'sd74961321;

    typedef struct packed {
        logic               polar;
        logic               bad;
        logic               origin;
        logic               flip;
        logic [4:0]         shift;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic signed [31:0] ang;
    } rpc_side_t;

    typedef struct packed {
        logic                  vectoring;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } rpc_vec_t;

    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0: v = 30'd843314857;
            1: v = 30'd497837829;
            2: v = 30'd263043837;
            3: v = 30'd133525159;
            4: v = 30'd67021687;
            5: v = 30'd33543516;
            6: v = 30'd16775851;
            7: v = 30'd8388437;
            8: v = 30'd4194283;
            9: v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            24: v = 30'd64;
            25: v = 30'd32;
            26: v = 30'd16;
            27: v = 30'd8;
            28: v = 30'd4;
            29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/rpc_pre.sv -----
// ============================================================================
// rpc_pre
// Front pipeline: half-plane turn, normalization, angle reduction and the
// initial products that feed the CORDIC stages.
// ============================================================================
module rpc_pre import rpc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] in_first,
    input  logic signed [31:0] in_second,
    input  logic [1:0]         in_form,
    output logic               out_valid,
    input  logic               out_ready,
    output rpc_side_t          out_side,
    output rpc_vec_t           out_vec
);

    localparam int  LOW_W  = FRAC_BITS + 3;
    localparam int  OFF    = 45 * (((1 << (28 - FRAC_BITS)) + 44) / 45);
    localparam logic [26:0] RECIP = 27'd95443718;
    localparam longint FULL_L = 64'sd360 <<< FRAC_BITS;
    localparam logic signed [33:0] FULL    = 34'(FULL_L);
    localparam logic signed [33:0] HALF    = 34'(FULL_L / 2);
    localparam logic signed [33:0] QUARTER = 34'(FULL_L / 4);
    localparam logic signed [33:0] Q3      = 34'((FULL_L / 4) * 3);

    function automatic logic [4:0] lzc32(input logic [31:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 5'(31 - i);
            end
        end
        return n;
    endfunction

    logic [5:0] v_reg;
    logic [5:0] adv;

    assign adv[5] = !v_reg[5] || out_ready;
    assign adv[4] = !v_reg[4] || adv[5];
    assign adv[3] = !v_reg[3] || adv[4];
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign adv[0] = !v_reg[0] || adv[1];
    assign in_ready  = adv[0];
    assign out_valid = v_reg[5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
            if (adv[4]) v_reg[4] <= v_reg[3];
            if (adv[5]) v_reg[5] <= v_reg[4];
        end
    end

    // Stage 1
    rpc_side_t          side1_reg, side1_next;
    logic signed [32:0] rx1_reg, rx1_next, ry1_reg, ry1_next;
    logic signed [33:0] rz1_reg, rz1_next;
    logic [21:0]        u1_reg, u1_next;
    logic [LOW_W-1:0]   low1_reg, low1_next;
    logic signed [58:0] angp1_reg, angp1_next;
    logic signed [61:0] gx1_reg, gx1_next;
    logic signed [31:0] p1;

    always_comb begin
        side1_next.polar  = (in_form == FORM_POLAR);
        side1_next.bad    = (in_form != FORM_RECT) && (in_form != FORM_POLAR);
        side1_next.origin = (in_first == 32'sd0) && (in_second == 32'sd0);
        side1_next.flip   = 1'b0;
        side1_next.shift  = '0;
        side1_next.first  = in_first;
        side1_next.second = in_second;
        side1_next.ang    = '0;
        rx1_next = in_first[31] ? -33'(in_first) : 33'(in_first);
        ry1_next = in_first[31] ? -33'(in_second) : 33'(in_second);
        if (in_first[31]) begin
            rz1_next = in_second[31] ? -PI_Q30 : PI_Q30;
        end else begin
            rz1_next = '0;
        end
        p1         = in_second >>> (FRAC_BITS + 3);
        u1_next    = 22'(p1 + 32'(OFF));
        low1_next  = in_second[LOW_W-1:0];
        angp1_next = in_second * DEG_TO_RAD_Q32;
        gx1_next   = in_first * GAIN_Q30;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            side1_reg <= side1_next;
            rx1_reg   <= rx1_next;
            ry1_reg   <= ry1_next;
            rz1_reg   <= rz1_next;
            u1_reg    <= u1_next;
            low1_reg  <= low1_next;
            angp1_reg <= angp1_next;
            gx1_reg   <= gx1_next;
        end
    end

    // Stage 2
    rpc_side_t          side2_reg, side2_next;
    logic signed [32:0] rx2_reg, ry2_reg;
    logic signed [33:0] rz2_reg;
    logic [31:0]        m2_reg, m2_next;
    logic [16:0]        quot2_reg, quot2_next;
    logic [21:0]        u2_reg;
    logic [LOW_W-1:0]   low2_reg;
    logic signed [61:0] gx2_reg;
    logic signed [32:0] ary;
    logic [48:0]        qprod;
    logic signed [59:0] angsum;

    always_comb begin
        ary        = ry1_reg[32] ? -ry1_reg : ry1_reg;
        m2_next    = (ary[31:0] > rx1_reg[31:0]) ? ary[31:0] : rx1_reg[31:0];
        qprod      = 49'(u1_reg) * 49'(RECIP);
        quot2_next = qprod[48:32];
        angsum     = 60'(angp1_reg) + 60'sd2147483648;
        side2_next     = side1_reg;
        side2_next.ang = 32'(angsum >>> 32);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            side2_reg <= side2_next;
            rx2_reg   <= rx1_reg;
            ry2_reg   <= ry1_reg;
            rz2_reg   <= rz1_reg;
            m2_reg    <= m2_next;
            quot2_reg <= quot2_next;
            u2_reg    <= u1_reg;
            low2_reg  <= low1_reg;
            gx2_reg   <= gx1_reg;
        end
    end

    // Stage 3
    rpc_side_t          side3_reg;
    logic signed [32:0] rx3_reg, ry3_reg;
    logic signed [33:0] rz3_reg;
    logic [4:0]         s3_reg, s3_next;
    logic signed [33:0] r3_reg, r3_next;
    logic signed [61:0] gx3_reg;
    logic [5:0]         rem3;

    always_comb begin
        s3_next = lzc32(m2_reg);
        rem3    = 6'(u2_reg - 22'(quot2_reg) * 22'd45);
        r3_next = (34'(rem3) << LOW_W) | 34'(low2_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            side3_reg <= side2_reg;
            rx3_reg   <= rx2_reg;
            ry3_reg   <= ry2_reg;
            rz3_reg   <= rz2_reg;
            s3_reg    <= s3_next;
            r3_reg    <= r3_next;
            gx3_reg   <= gx2_reg;
        end
    end

    // Stage 4
    rpc_side_t          side4_reg, side4_next;
    logic signed [33:0] xn4_reg, xn4_next, yn4_reg, yn4_next;
    logic signed [33:0] rz4_reg;
    logic signed [31:0] r4_reg, r4_next;
    logic signed [61:0] gx4_reg;

    always_comb begin
        xn4_next         = 34'(rx3_reg) <<< s3_reg;
        yn4_next         = 34'(ry3_reg) <<< s3_reg;
        side4_next       = side3_reg;
        side4_next.shift = s3_reg;
        if (r3_reg <= QUARTER) begin
            r4_next         = 32'(r3_reg);
            side4_next.flip = 1'b0;
        end else if (r3_reg < Q3) begin
            r4_next         = 32'(r3_reg - HALF);
            side4_next.flip = 1'b1;
        end else begin
            r4_next         = 32'(r3_reg - FULL);
            side4_next.flip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            side4_reg <= side4_next;
            xn4_reg   <= xn4_next;
            yn4_reg   <= yn4_next;
            rz4_reg   <= rz3_reg;
            r4_reg    <= r4_next;
            gx4_reg   <= gx3_reg;
        end
    end

    // Stage 5
    rpc_side_t          side5_reg;
    logic signed [33:0] xn5_reg, yn5_reg, rz5_reg;
    logic signed [Z_W-1:0] z5_reg, z5_next;
    logic signed [61:0] gx5_reg;
    logic signed [58:0] zprod;

    always_comb begin
        zprod   = r4_reg * DEG_TO_RAD_Q32;
        z5_next = Z_W'(zprod >>> (FRAC_BITS + 2));
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            side5_reg <= side4_reg;
            xn5_reg   <= xn4_reg;
            yn5_reg   <= yn4_reg;
            rz5_reg   <= rz4_reg;
            z5_reg    <= z5_next;
            gx5_reg   <= gx4_reg;
        end
    end

    // Stage 6
    rpc_side_t out_side_reg;
    rpc_vec_t  out_vec_reg, out_vec_next;

    always_comb begin
        if (side5_reg.polar) begin
            out_vec_next.vectoring = 1'b0;
            out_vec_next.x         = XY_W'(gx5_reg);
            out_vec_next.y         = '0;
            out_vec_next.z         = z5_reg;
        end else begin
            out_vec_next.vectoring = 1'b1;
            out_vec_next.x         = XY_W'(xn5_reg);
            out_vec_next.y         = XY_W'(yn5_reg);
            out_vec_next.z         = Z_W'(rz5_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            out_side_reg <= side5_reg;
            out_vec_reg  <= out_vec_next;
        end
    end

    assign out_side = out_side_reg;
    assign out_vec  = out_vec_reg;

endmodule

// ----- src/rpc_cordic_stage.sv -----
// ============================================================================
// rpc_cordic_stage
// One registered CORDIC micro-rotation, vectoring or rotation per item.
// ============================================================================
module rpc_cordic_stage import rpc_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  rpc_side_t in_side,
    input  rpc_vec_t  in_vec,
    output logic      out_valid,
    input  logic      out_ready,
    output rpc_side_t out_side,
    output rpc_vec_t  out_vec
);

    logic                   valid_reg;
    rpc_side_t              side_reg;
    rpc_vec_t               vec_reg, vec_next;
    logic signed [XY_W-1:0] xi, yi, dx, dy;
    logic signed [Z_W-1:0]  zi, at;
    logic                   neg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xi  = in_vec.x;
        yi  = in_vec.y;
        zi  = in_vec.z;
        dx  = yi >>> IDX;
        dy  = xi >>> IDX;
        at  = Z_W'(atan_q30(IDX));
        neg = in_vec.vectoring ? !yi[XY_W-1] : zi[Z_W-1];
        vec_next.vectoring = in_vec.vectoring;
        if (neg) begin
            vec_next.x = xi + dx;
            vec_next.y = yi - dy;
            vec_next.z = zi + at;
        end else begin
            vec_next.x = xi - dx;
            vec_next.y = yi + dy;
            vec_next.z = zi - at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            side_reg <= in_side;
            vec_reg  <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_vec   = vec_reg;

endmodule

// ----- src/rpc_post.sv -----
// ============================================================================
// rpc_post
// Back pipeline: gain correction, denormalization, rounding, saturation and
// the output register.
// ============================================================================
module rpc_post import rpc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpc_side_t          in_side,
    input  rpc_vec_t           in_vec,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic signed [33:0] magnitude,
    output logic signed [31:0] angle_rad,
    output logic               bad_form
);

    localparam logic signed [Z_W-1:0] ZRND = Z_W'(64'd1 << (29 - FRAC_BITS));
    localparam logic [29:0] GAIN_U = 30'(GAIN_Q30);

    logic [3:0] v_reg;
    logic [3:0] adv;

    assign adv[3] = !v_reg[3] || out_ready;
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign adv[0] = !v_reg[0] || adv[1];
    assign in_ready  = adv[0];
    assign out_valid = v_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    // Stage 1
    rpc_side_t          side1_reg;
    logic [47:0]        tph1_reg, tph1_next, tpl1_reg, tpl1_next;
    logic signed [33:0] xr1_reg, xr1_next, yr1_reg, yr1_next;
    logic signed [31:0] za1_reg, za1_next;
    logic [35:0]        t1;
    logic signed [XY_W-1:0] xsum, ysum;
    logic signed [Z_W-1:0]  zsum;

    always_comb begin
        t1        = in_vec.x[XY_W-1] ? 36'd0 : in_vec.x[35:0];
        tph1_next = 48'(t1[35:18]) * 48'(GAIN_U);
        tpl1_next = 48'(t1[17:0]) * 48'(GAIN_U);
        xsum      = in_vec.x + 64'sd536870912;
        ysum      = in_vec.y + 64'sd536870912;
        xr1_next  = 34'(xsum >>> 30);
        yr1_next  = 34'(ysum >>> 30);
        zsum      = in_vec.z + ZRND;
        za1_next  = 32'(zsum >>> (30 - FRAC_BITS));
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            side1_reg <= in_side;
            tph1_reg  <= tph1_next;
            tpl1_reg  <= tpl1_next;
            xr1_reg   <= xr1_next;
            yr1_reg   <= yr1_next;
            za1_reg   <= za1_next;
        end
    end

    // Stage 2
    rpc_side_t          side2_reg;
    logic [63:0]        prod2_reg, prod2_next;
    logic signed [34:0] xs2_reg, xs2_next, ys2_reg, ys2_next;
    logic signed [31:0] za2_reg;

    always_comb begin
        prod2_next = (64'(tph1_reg) << 18) + 64'(tpl1_reg);
        xs2_next   = side1_reg.flip ? -35'(xr1_reg) : 35'(xr1_reg);
        ys2_next   = side1_reg.flip ? -35'(yr1_reg) : 35'(yr1_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            side2_reg <= side1_reg;
            prod2_reg <= prod2_next;
            xs2_reg   <= xs2_next;
            ys2_reg   <= ys2_next;
            za2_reg   <= za1_reg;
        end
    end

    // Stage 3
    rpc_side_t          side3_reg;
    logic [63:0]        msum3_reg, msum3_next;
    logic signed [31:0] xsat3_reg, xsat3_next, ysat3_reg, ysat3_next;
    logic signed [31:0] za3_reg;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    always_comb begin
        msum3_next = prod2_reg + (64'd1 << (6'(side2_reg.shift) + 6'd29));
        xsat3_next = sat32(xs2_reg);
        ysat3_next = sat32(ys2_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            side3_reg <= side2_reg;
            msum3_reg <= msum3_next;
            xsat3_reg <= xsat3_next;
            ysat3_reg <= ysat3_next;
            za3_reg   <= za2_reg;
        end
    end

    // Stage 4: output register
    logic signed [31:0] x_reg, x_next, y_reg, y_next, a_reg, a_next;
    logic signed [33:0] m_reg, m_next;
    logic               bad_reg;
    logic [63:0]        mshift;

    always_comb begin
        mshift = msum3_reg >> (6'(side3_reg.shift) + 6'd30);
        if (side3_reg.bad) begin
            x_next = '0;
            y_next = '0;
            m_next = '0;
            a_next = '0;
        end else if (side3_reg.polar) begin
            x_next = xsat3_reg;
            y_next = ysat3_reg;
            m_next = 34'(side3_reg.first);
            a_next = side3_reg.ang;
        end else begin
            x_next = side3_reg.first;
            y_next = side3_reg.second;
            m_next = side3_reg.origin ? 34'sd0 : 34'(mshift);
            a_next = side3_reg.origin ? 32'sd0 : za3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            m_reg   <= m_next;
            a_reg   <= a_next;
            bad_reg <= side3_reg.bad;
        end
    end

    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign magnitude = m_reg;
    assign angle_rad = a_reg;
    assign bad_form  = bad_reg;

endmodule

// ----- src/rect_polar_converter.sv -----
// ============================================================================
// rect_polar_converter
// Pipelined CORDIC converter between rectangular and polar Q16.16 vectors.
// ============================================================================
// One vector enters per clock when the output side keeps up, and each result
// passes through six front stages, one register per CORDIC micro-rotation and
// four back stages including the output register. Every stage holds its own
// valid bit and stalls only when the stage after it is full, so gaps in the
// stream are squeezed out during backpressure. tuser selects the form: zero
// for rectangular input (x, y), one for polar input (magnitude, angle in
// degrees); other codes return all-zero data with the m_tuser flag set.
module rect_polar_converter import rpc_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_value, second_value
    input  logic [63:0]  s_tdata,
    // form
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // x_out, y_out, magnitude, angle_rad, zero padding
    output logic [135:0] m_tdata,
    // bad_form
    output logic         m_tuser
);

    localparam int NST = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    logic      vld_w [NST+1];
    logic      rdy_w [NST+1];
    rpc_side_t side_w[NST+1];
    rpc_vec_t  vec_w [NST+1];

    logic signed [31:0] x_out, y_out, angle_rad;
    logic signed [33:0] magnitude;

    rpc_pre #(
        .FRAC_BITS(FRAC_BITS)
    ) u_pre (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_first (s_tdata[31:0]),
        .in_second(s_tdata[63:32]),
        .in_form  (s_tuser),
        .out_valid(vld_w[0]),
        .out_ready(rdy_w[0]),
        .out_side (side_w[0]),
        .out_vec  (vec_w[0])
    );

    for (genvar i = 0; i < NST; i++) begin : g_cordic
        rpc_cordic_stage #(
            .IDX(i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (vld_w[i]),
            .in_ready (rdy_w[i]),
            .in_side  (side_w[i]),
            .in_vec   (vec_w[i]),
            .out_valid(vld_w[i+1]),
            .out_ready(rdy_w[i+1]),
            .out_side (side_w[i+1]),
            .out_vec  (vec_w[i+1])
        );
    end

    rpc_post #(
        .FRAC_BITS(FRAC_BITS)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld_w[NST]),
        .in_ready (rdy_w[NST]),
        .in_side  (side_w[NST]),
        .in_vec   (vec_w[NST]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .x_out    (x_out),
        .y_out    (y_out),
        .magnitude(magnitude),
        .angle_rad(angle_rad),
        .bad_form (m_tuser)
    );

    assign m_tdata = {6'd0, angle_rad, magnitude, y_out, x_out};

`ifndef SYNTHESIS
    // An invalid form must come out with every data field cleared.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("invalid-form result carries nonzero data");

    // A draining output makes every stage ready back to the input.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready && rdy_w[NST])
        else $error("ready chain blocked while output drains");

    // Reset empties the whole pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !vld_w[NST] && !vld_w[0])
        else $error("pipeline holds a beat after reset");
`endif

endmodule
